### src/mvt_pkg.sv
package mvt_pkg;

  localparam int unsigned DIM         = 4;
  localparam int unsigned NUM_ENTRIES = DIM * DIM;
  localparam int unsigned IDX_W       = $clog2(NUM_ENTRIES);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned PROD_W      = 2 * DATA_W;
  localparam int unsigned PAIR_W      = PROD_W + 1;
  localparam int unsigned SUM_W       = PROD_W + 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam data_t Q_ONE    = data_t'(1) <<< FRAC_W;
  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  typedef data_t [NUM_ENTRIES-1:0] matrix_t;
  typedef data_t [DIM-1:0]         vec_t;
  typedef prod_t [DIM-1:0]         prod_row_t;
  typedef prod_row_t [DIM-1:0]     prod_mat_t;

  // products of one vector word, handed from the multiply stage to the adders
  typedef struct packed {
    logic      valid;
    prod_mat_t prod;
  } prod_stage_t;

  typedef struct packed {
    data_t value;
    logic  sat;
  } sat_res_t;

  // identity matrix in q16.16: one on the diagonal
  function automatic matrix_t identity_matrix();
    matrix_t m;
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      idx  = IDX_W'(i);
      m[i] = (idx[IDX_W-1:IDX_W/2] == idx[IDX_W/2-1:0]) ? Q_ONE : '0;
    end
    return m;
  endfunction

  // signed 32x32 multiply, full 64-bit product
  function automatic prod_t mul_q(data_t a, data_t b);
    prod_t p;
    p = a * b;
    return p;
  endfunction

  // floor of sum / 2^16, clamped to the 32-bit signed range
  function automatic sat_res_t saturate(sum_t s);
    sat_res_t res;
    logic     fits;
    fits = (&s[SUM_W-1:FRAC_W+DATA_W-1]) || !(|s[SUM_W-1:FRAC_W+DATA_W-1]);
    if (fits) begin
      res.value = data_t'(s[FRAC_W+DATA_W-1:FRAC_W]);
      res.sat   = 1'b0;
    end else begin
      res.value = s[SUM_W-1] ? DATA_MIN : DATA_MAX;
      res.sat   = 1'b1;
    end
    return res;
  endfunction

endpackage

### src/mvt_if.sv
interface mvt_in_if import mvt_pkg::*;;
  logic                valid;
  logic                ready;
  logic                operation;
  logic [IDX_W-1:0]    entry_index;
  logic signed [31:0]  entry_value;
  logic signed [31:0]  vec_x;
  logic signed [31:0]  vec_y;
  logic signed [31:0]  vec_z;
  logic signed [31:0]  vec_w;

  modport source (
    output valid, operation, entry_index, entry_value, vec_x, vec_y, vec_z, vec_w,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_value, vec_x, vec_y, vec_z, vec_w,
    output ready
  );
endinterface

interface mvt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               saturated;

  modport source (
    output valid, out_x, out_y, out_z, out_w, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, saturated,
    output ready
  );
endinterface

### src/mvt_mac_stage.sv
module mvt_mac_stage import mvt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [IDX_W-1:0] entry_index_i,
  input  data_t            entry_value_i,
  input  vec_t             vec_i,
  output prod_stage_t      prod_o,
  input  logic             prod_ready_i
);

  matrix_t     matrix_q;
  logic        prod_valid_q;
  prod_mat_t   prod_data_q;
  prod_mat_t   prod_d;
  logic        accept;
  logic        is_load;
  logic        is_xform;

  // stage moves when empty or when the adders take its word
  assign in_ready_o = !prod_valid_q || prod_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_load    = accept && (operation_i == OP_LOAD);
  assign is_xform   = accept && (operation_i == OP_XFORM);

  // matrix store, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q <= identity_matrix();
    end else if (is_load) begin
      matrix_q[entry_index_i] <= entry_value_i;
    end
  end

  // sixteen products, one per matrix entry
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        prod_d[r][c] = mul_q(matrix_q[r*DIM+c], vec_i[c]);
      end
    end
  end

  // product register with valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      prod_valid_q <= is_xform;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_xform) begin
      prod_data_q <= prod_d;
    end
  end

  assign prod_o = '{valid: prod_valid_q, prod: prod_data_q};

`ifndef SYNTHESIS
  a_load_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_load |=> !prod_valid_q)
    else $error("load word entered the product stage");

  a_matrix_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !is_load |=> $stable(matrix_q))
    else $error("matrix changed without a load");

  a_prod_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_valid_q && !prod_ready_i) |=> (prod_valid_q && $stable(prod_data_q)))
    else $error("product stage lost or changed a stalled word");
`endif

endmodule

### src/mvt_sum_stage.sv
module mvt_sum_stage import mvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  prod_stage_t prod_i,
  output logic        prod_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output vec_t        res_o,
  output logic        sat_o
);

  logic     pair_valid_q;
  pair_t    pair_q [DIM][2];
  pair_t    pair_d [DIM][2];
  logic     out_valid_q;
  vec_t     res_q;
  vec_t     res_d;
  logic     sat_q;
  logic     sat_d;
  logic     out_en;
  logic     pair_en;
  sat_res_t row_res [DIM];

  assign out_en       = !out_valid_q || out_ready_i;
  assign pair_en      = !pair_valid_q || out_en;
  assign prod_ready_o = pair_en;

  // first adder level: two pair sums per row
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int h = 0; h < 2; h++) begin
        pair_d[r][h] = PAIR_W'(signed'(prod_i.prod[r][2*h])) +
                       PAIR_W'(signed'(prod_i.prod[r][2*h+1]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_valid_q <= 1'b0;
    end else if (pair_en) begin
      pair_valid_q <= prod_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_en && prod_i.valid) begin
      pair_q <= pair_d;
    end
  end

  // final add, drop fraction bits, clamp
  always_comb begin
    sat_d = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      row_res[r] = saturate(SUM_W'(pair_q[r][0]) + SUM_W'(pair_q[r][1]));
      res_d[r]   = row_res[r].value;
      sat_d      = sat_d | row_res[r].sat;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= pair_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && pair_valid_q) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign sat_o       = sat_q;

`ifndef SYNTHESIS
  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && sat_q) |->
      (res_q[0] == DATA_MAX || res_q[0] == DATA_MIN ||
       res_q[1] == DATA_MAX || res_q[1] == DATA_MIN ||
       res_q[2] == DATA_MAX || res_q[2] == DATA_MIN ||
       res_q[3] == DATA_MAX || res_q[3] == DATA_MIN))
    else $error("saturated flag set with no component at a bound");

  a_pair_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair_valid_q && !out_en) |=> pair_valid_q)
    else $error("adder stage dropped a stalled word");

  a_pair_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair_valid_q && out_en) |=> out_valid_q)
    else $error("adder word did not reach the output register");
`endif

endmodule

### src/matrix_vector_transform_4x4_core.sv
// 4x4 vertex transform, signed q16.16, matrix resets to identity.
// a transform word passes through the multiply stage, the pair adders and the final add with clamp
// into the output register before it shows at the output.
// throughput: one word per cycle while the output is not stalled; a load word gives no result.
// rst_ni is asynchronous active low: clears all valid bits and sets the matrix to identity.
module matrix_vector_transform_4x4_core import mvt_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  mvt_in_if.sink   in_i,
  mvt_out_if.source out_o
);

  prod_stage_t prod;
  logic        prod_ready;
  vec_t        vec;
  vec_t        res;
  logic        sat;
  logic        out_valid;

  // gather the vector word
  assign vec[0] = in_i.vec_x;
  assign vec[1] = in_i.vec_y;
  assign vec[2] = in_i.vec_z;
  assign vec[3] = in_i.vec_w;

  mvt_mac_stage u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .operation_i   (in_i.operation),
    .entry_index_i (in_i.entry_index),
    .entry_value_i (in_i.entry_value),
    .vec_i         (vec),
    .prod_o        (prod),
    .prod_ready_i  (prod_ready)
  );

  mvt_sum_stage u_sum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_i       (prod),
    .prod_ready_o (prod_ready),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .res_o        (res),
    .sat_o        (sat)
  );

  // result word
  assign out_o.valid     = out_valid;
  assign out_o.out_x     = res[0];
  assign out_o.out_y     = res[1];
  assign out_o.out_z     = res[2];
  assign out_o.out_w     = res[3];
  assign out_o.saturated = sat;

endmodule

### dv/mvt_checker.sv
module mvt_checker import mvt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mvt_in_if    in_mon,
  mvt_out_if   out_mon,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    data_t x;
    data_t y;
    data_t z;
    data_t w;
    logic  sat;
  } vertex_t;

  data_t   matrix_q [NUM_ENTRIES];
  vertex_t vertex_fifo [$];
  int      mismatches = 0;

  assign errors_o  = mismatches;
  assign pending_o = vertex_fifo.size();

  // each row dot vector: exact 66-bit sum, floor by 16 bits, clamp to 32 bits
  function automatic vertex_t transform_vertex(data_t vx, data_t vy, data_t vz, data_t vw);
    data_t   vec [DIM];
    data_t   row_res [DIM];
    sum_t    acc;
    vertex_t res;
    vec     = '{vx, vy, vz, vw};
    res.sat = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      acc = '0;
      for (int c = 0; c < DIM; c++) begin
        acc += sum_t'(prod_t'(matrix_q[r*DIM+c]) * prod_t'(vec[c]));
      end
      acc = acc >>> FRAC_W;
      if (acc > sum_t'(DATA_MAX)) begin
        row_res[r] = DATA_MAX;
        res.sat    = 1'b1;
      end else if (acc < sum_t'(DATA_MIN)) begin
        row_res[r] = DATA_MIN;
        res.sat    = 1'b1;
      end else begin
        row_res[r] = data_t'(acc);
      end
    end
    res.x = row_res[0];
    res.y = row_res[1];
    res.z = row_res[2];
    res.w = row_res[3];
    return res;
  endfunction

  // returns one on mismatch
  function automatic int check_field(string name, logic [DATA_W-1:0] exp_v,
                                     logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // watch both channels, track the matrix and compare each result word
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t exp_v;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        matrix_q[i] = (i % (DIM + 1) == 0) ? Q_ONE : '0;
      end
      vertex_fifo.delete();
    end else begin
      // result side
      if (out_mon.valid && out_mon.ready) begin
        if (vertex_fifo.size() == 0) begin
          $error("result word with no expectation: x %h y %h z %h w %h sat %b",
                 out_mon.out_x, out_mon.out_y, out_mon.out_z, out_mon.out_w,
                 out_mon.saturated);
          mismatches++;
        end else begin
          exp_v = vertex_fifo.pop_front();
          mismatches += check_field("out_x", exp_v.x, out_mon.out_x);
          mismatches += check_field("out_y", exp_v.y, out_mon.out_y);
          mismatches += check_field("out_z", exp_v.z, out_mon.out_z);
          mismatches += check_field("out_w", exp_v.w, out_mon.out_w);
          mismatches += check_field("saturated", DATA_W'(exp_v.sat),
                                    DATA_W'(out_mon.saturated));
        end
      end
      // input side
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_LOAD) begin
          matrix_q[in_mon.entry_index] = in_mon.entry_value;
        end else begin
          vertex_fifo.push_back(transform_vertex(in_mon.vec_x, in_mon.vec_y,
                                                 in_mon.vec_z, in_mon.vec_w));
        end
      end
    end
  end

endmodule

### dv/tb_top.sv
module tb_top import mvt_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   err_count;
  int   exp_pending;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_off_reqs  = 0;

  mvt_in_if  in_if ();
  mvt_out_if out_if ();

  matrix_vector_transform_4x4_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mvt_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .errors_o  (err_count),
    .pending_o (exp_pending)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls plus long hold-offs on request
  initial begin
    int hold_cnt;
    int holds_done;
    hold_cnt   = 0;
    holds_done = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt == 0 && hold_off_reqs > holds_done) begin
        holds_done++;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        out_if.ready <= 1'b0;
        hold_cnt--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // offer one word and wait until it is taken
  task automatic send_word(op_e op, logic [IDX_W-1:0] idx, data_t value,
                           data_t vx, data_t vy, data_t vz, data_t vw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.entry_index <= idx;
    in_if.entry_value <= value;
    in_if.vec_x       <= vx;
    in_if.vec_y       <= vy;
    in_if.vec_z       <= vz;
    in_if.vec_w       <= vw;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic load_entry(int idx, data_t value);
    send_word(OP_LOAD, IDX_W'(idx), value, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic transform_vec(data_t vx, data_t vy, data_t vz, data_t vw);
    send_word(OP_XFORM, IDX_W'($urandom), $urandom, vx, vy, vz, vw);
  endtask

  // q16.16 value: extremes, small magnitudes or any 32-bit pattern
  function automatic data_t rand_q();
    case ($urandom_range(0, 9))
      0:       return DATA_MAX;
      1:       return DATA_MIN;
      2:       return '0;
      3:       return Q_ONE;
      4, 5, 6: return data_t'($urandom_range(0, 32'h0010_0000)) - data_t'(32'h0008_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_word();
    if ($urandom_range(0, 99) < 15) begin
      load_entry($urandom_range(0, NUM_ENTRIES - 1), rand_q());
    end else begin
      transform_vec(rand_q(), rand_q(), rand_q(), rand_q());
    end
  endtask

  // stimulus and verdict
  initial begin
    int wait_cnt;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.operation   <= OP_LOAD;
    in_if.entry_index <= '0;
    in_if.entry_value <= '0;
    in_if.vec_x       <= '0;
    in_if.vec_y       <= '0;
    in_if.vec_z       <= '0;
    in_if.vec_w       <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity after reset passes the vector through
    transform_vec(DATA_MAX, DATA_MIN, '0, -1);
    // large row 0 entries overflow upward
    load_entry(0, DATA_MAX);
    load_entry(1, DATA_MAX);
    transform_vec(DATA_MAX, DATA_MAX, '0, '0);
    // most negative diagonal entry overflows downward
    load_entry(5, DATA_MIN);
    transform_vec(DATA_MAX, DATA_MAX, Q_ONE, '0);
    // tiny products floor toward minus infinity: negative ones to minus one lsb
    load_entry(10, 1);
    load_entry(15, -1);
    transform_vec('0, '0, -1, 3);
    transform_vec('0, '0, 32'h0000_FFFF, -32'sh0001_0001);
    // full negative row times full negative vector needs the widest sum
    load_entry(12, DATA_MIN);
    load_entry(13, DATA_MIN);
    load_entry(14, DATA_MIN);
    load_entry(15, DATA_MIN);
    transform_vec(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
    transform_vec(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN);
    // mixed signs in row 0 that cancel without clamping
    load_entry(2, DATA_MIN);
    load_entry(3, DATA_MIN);
    transform_vec(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
    transform_vec('0, '0, '0, '0);

    // random phases: no idling, sender idle, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      repeat (400) random_word();
    end

    // long receiver hold-off while words keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_reqs++;
    repeat (150) random_word();
    in_if.valid <= 1'b0;

    // drain
    wait_cnt = 0;
    while (exp_pending != 0 && wait_cnt < 20000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (8) @(posedge clk_i);
    if (exp_pending != 0) begin
      $error("%0d expected result words never arrived", exp_pending);
    end
    if (err_count == 0 && exp_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
src/mvt_pkg.sv
src/mvt_if.sv
src/mvt_mac_stage.sv
src/mvt_sum_stage.sv
src/matrix_vector_transform_4x4_core.sv
dv/mvt_checker.sv
dv/tb_top.sv
